/* hw/rtl/rvx_pkg.sv */
// rvx_pkg: shared types, operation codes and constants for the rv32im execute unit
// no dependencies; used by the interfaces and every module of the block
package rvx_pkg;

   // operation codes of an incoming word
   localparam logic [5:0] OP_ADD    = 6'd0;
   localparam logic [5:0] OP_SUB    = 6'd1;
   localparam logic [5:0] OP_XOR    = 6'd2;
   localparam logic [5:0] OP_OR     = 6'd3;
   localparam logic [5:0] OP_AND    = 6'd4;
   localparam logic [5:0] OP_SLL    = 6'd5;
   localparam logic [5:0] OP_SRL    = 6'd6;
   localparam logic [5:0] OP_SRA    = 6'd7;
   localparam logic [5:0] OP_SLT    = 6'd8;
   localparam logic [5:0] OP_SLTU   = 6'd9;
   localparam logic [5:0] OP_ADDI   = 6'd10;
   localparam logic [5:0] OP_XORI   = 6'd11;
   localparam logic [5:0] OP_ORI    = 6'd12;
   localparam logic [5:0] OP_ANDI   = 6'd13;
   localparam logic [5:0] OP_SLLI   = 6'd14;
   localparam logic [5:0] OP_SRLI   = 6'd15;
   localparam logic [5:0] OP_SRAI   = 6'd16;
   localparam logic [5:0] OP_SLTI   = 6'd17;
   localparam logic [5:0] OP_SLTIU  = 6'd18;
   localparam logic [5:0] OP_MUL    = 6'd19;
   localparam logic [5:0] OP_MULH   = 6'd20;
   localparam logic [5:0] OP_MULHSU = 6'd21;
   localparam logic [5:0] OP_MULHU  = 6'd22;
   localparam logic [5:0] OP_DIV    = 6'd23;
   localparam logic [5:0] OP_DIVU   = 6'd24;
   localparam logic [5:0] OP_REM    = 6'd25;
   localparam logic [5:0] OP_REMU   = 6'd26;
   localparam logic [5:0] OP_BEQ    = 6'd27;
   localparam logic [5:0] OP_BNE    = 6'd28;
   localparam logic [5:0] OP_BLT    = 6'd29;
   localparam logic [5:0] OP_BGE    = 6'd30;
   localparam logic [5:0] OP_BLTU   = 6'd31;
   localparam logic [5:0] OP_BGEU   = 6'd32;
   localparam logic [5:0] OP_JAL    = 6'd33;
   localparam logic [5:0] OP_JALR   = 6'd34;
   localparam logic [5:0] OP_LUI    = 6'd35;
   localparam logic [5:0] OP_AUIPC  = 6'd36;

   // instruction classes
   localparam logic [3:0] K_NOP   = 4'd0;
   localparam logic [3:0] K_ALU   = 4'd1;
   localparam logic [3:0] K_MUL   = 4'd2;
   localparam logic [3:0] K_DIV   = 4'd3;
   localparam logic [3:0] K_BR    = 4'd4;
   localparam logic [3:0] K_JAL   = 4'd5;
   localparam logic [3:0] K_JALR  = 4'd6;
   localparam logic [3:0] K_LUI   = 4'd7;
   localparam logic [3:0] K_AUIPC = 4'd8;

   // function codes within a class
   localparam logic [3:0] F_ADD  = 4'd0;
   localparam logic [3:0] F_SUB  = 4'd1;
   localparam logic [3:0] F_XOR  = 4'd2;
   localparam logic [3:0] F_OR   = 4'd3;
   localparam logic [3:0] F_AND  = 4'd4;
   localparam logic [3:0] F_SLL  = 4'd5;
   localparam logic [3:0] F_SRL  = 4'd6;
   localparam logic [3:0] F_SRA  = 4'd7;
   localparam logic [3:0] F_SLT  = 4'd8;
   localparam logic [3:0] F_SLTU = 4'd9;

   localparam logic [3:0] F_MUL    = 4'd0;
   localparam logic [3:0] F_MULH   = 4'd1;
   localparam logic [3:0] F_MULHSU = 4'd2;
   localparam logic [3:0] F_MULHU  = 4'd3;

   localparam logic [3:0] F_DIV  = 4'd0;
   localparam logic [3:0] F_DIVU = 4'd1;
   localparam logic [3:0] F_REM  = 4'd2;
   localparam logic [3:0] F_REMU = 4'd3;

   localparam logic [3:0] F_BEQ  = 4'd0;
   localparam logic [3:0] F_BNE  = 4'd1;
   localparam logic [3:0] F_BLT  = 4'd2;
   localparam logic [3:0] F_BGE  = 4'd3;
   localparam logic [3:0] F_BLTU = 4'd4;
   localparam logic [3:0] F_BGEU = 4'd5;

   localparam int UPPER_SHIFT = 12;
   localparam logic [31:0] INSN_BYTES = 32'd4;

   // one divider step per pipeline stage
   localparam int DIV_STEPS = 32;

   // decoupling queue between decode and execute
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   typedef struct packed {
      logic [5:0]         operation;
      logic signed [31:0] source_a;
      logic signed [31:0] source_b;
      logic signed [31:0] immediate;
      logic [31:0]        program_counter;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               write_enable;
      logic               branch_taken;
      logic [31:0]        next_address;
      logic               divide_by_zero;
   } rsp_type;

   // decoded word handed from front to back
   typedef struct packed {
      logic [3:0]  kind;
      logic [3:0]  fn;
      logic [31:0] opa;
      logic [31:0] opb;
      logic [31:0] imm;
      logic [31:0] pc;
   } dec_type;

endpackage

/* hw/rtl/rvx_if.sv */
// rvx_req_if and rvx_rsp_if: valid/ready channels of the execute unit
// depends on rvx_pkg for the payload types
interface rvx_req_if;
   logic             valid;
   logic             ready;
   rvx_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rvx_rsp_if;
   logic             valid;
   logic             ready;
   rvx_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/rvx_front.sv */
// rvx_front: accepts request words, classifies them and queues the decoded words
// depends on rvx_pkg and rvx_req_if
module rvx_front (
   input  logic              clock,
   input  logic              reset,
   rvx_req_if.sink           req_channel,
   output logic              dec_valid,
   output rvx_pkg::dec_type  dec_data,
   input  logic              dec_ready
);

   rvx_pkg::dec_type        q_ff [rvx_pkg::QDEPTH];
   logic [rvx_pkg::QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rvx_pkg::QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rvx_pkg::QAW:0]   count_ff, count_in;
   rvx_pkg::dec_type        dec_word;
   logic                    push, pop;

   // classify the incoming word
   always_comb begin
      dec_word.opa  = req_channel.payload.source_a;
      dec_word.opb  = req_channel.payload.source_b;
      dec_word.imm  = req_channel.payload.immediate;
      dec_word.pc   = req_channel.payload.program_counter;
      dec_word.kind = rvx_pkg::K_NOP;
      dec_word.fn   = rvx_pkg::F_ADD;
      case (req_channel.payload.operation)
         rvx_pkg::OP_ADD:    begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_ADD; end
         rvx_pkg::OP_SUB:    begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SUB; end
         rvx_pkg::OP_XOR:    begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_XOR; end
         rvx_pkg::OP_OR:     begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_OR; end
         rvx_pkg::OP_AND:    begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_AND; end
         rvx_pkg::OP_SLL:    begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SLL; end
         rvx_pkg::OP_SRL:    begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SRL; end
         rvx_pkg::OP_SRA:    begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SRA; end
         rvx_pkg::OP_SLT:    begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SLT; end
         rvx_pkg::OP_SLTU:   begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SLTU; end
         rvx_pkg::OP_ADDI:   begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_ADD; end
         rvx_pkg::OP_XORI:   begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_XOR; end
         rvx_pkg::OP_ORI:    begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_OR; end
         rvx_pkg::OP_ANDI:   begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_AND; end
         rvx_pkg::OP_SLLI:   begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SLL; end
         rvx_pkg::OP_SRLI:   begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SRL; end
         rvx_pkg::OP_SRAI:   begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SRA; end
         rvx_pkg::OP_SLTI:   begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SLT; end
         rvx_pkg::OP_SLTIU:  begin dec_word.kind = rvx_pkg::K_ALU; dec_word.fn = rvx_pkg::F_SLTU; end
         rvx_pkg::OP_MUL:    begin dec_word.kind = rvx_pkg::K_MUL; dec_word.fn = rvx_pkg::F_MUL; end
         rvx_pkg::OP_MULH:   begin dec_word.kind = rvx_pkg::K_MUL; dec_word.fn = rvx_pkg::F_MULH; end
         rvx_pkg::OP_MULHSU: begin
            dec_word.kind = rvx_pkg::K_MUL;
            dec_word.fn   = rvx_pkg::F_MULHSU;
         end
         rvx_pkg::OP_MULHU:  begin dec_word.kind = rvx_pkg::K_MUL; dec_word.fn = rvx_pkg::F_MULHU; end
         rvx_pkg::OP_DIV:    begin dec_word.kind = rvx_pkg::K_DIV; dec_word.fn = rvx_pkg::F_DIV; end
         rvx_pkg::OP_DIVU:   begin dec_word.kind = rvx_pkg::K_DIV; dec_word.fn = rvx_pkg::F_DIVU; end
         rvx_pkg::OP_REM:    begin dec_word.kind = rvx_pkg::K_DIV; dec_word.fn = rvx_pkg::F_REM; end
         rvx_pkg::OP_REMU:   begin dec_word.kind = rvx_pkg::K_DIV; dec_word.fn = rvx_pkg::F_REMU; end
         rvx_pkg::OP_BEQ:    begin dec_word.kind = rvx_pkg::K_BR; dec_word.fn = rvx_pkg::F_BEQ; end
         rvx_pkg::OP_BNE:    begin dec_word.kind = rvx_pkg::K_BR; dec_word.fn = rvx_pkg::F_BNE; end
         rvx_pkg::OP_BLT:    begin dec_word.kind = rvx_pkg::K_BR; dec_word.fn = rvx_pkg::F_BLT; end
         rvx_pkg::OP_BGE:    begin dec_word.kind = rvx_pkg::K_BR; dec_word.fn = rvx_pkg::F_BGE; end
         rvx_pkg::OP_BLTU:   begin dec_word.kind = rvx_pkg::K_BR; dec_word.fn = rvx_pkg::F_BLTU; end
         rvx_pkg::OP_BGEU:   begin dec_word.kind = rvx_pkg::K_BR; dec_word.fn = rvx_pkg::F_BGEU; end
         rvx_pkg::OP_JAL:    dec_word.kind = rvx_pkg::K_JAL;
         rvx_pkg::OP_JALR:   dec_word.kind = rvx_pkg::K_JALR;
         rvx_pkg::OP_LUI:    dec_word.kind = rvx_pkg::K_LUI;
         rvx_pkg::OP_AUIPC:  dec_word.kind = rvx_pkg::K_AUIPC;
         default:            dec_word.kind = rvx_pkg::K_NOP;
      endcase
      // immediate forms take the immediate as second operand
      if (req_channel.payload.operation inside {[rvx_pkg::OP_ADDI:rvx_pkg::OP_SLTIU]}) begin
         dec_word.opb = req_channel.payload.immediate;
      end
   end

   // queue control
   assign req_channel.ready = (count_ff != (rvx_pkg::QAW+1)'(rvx_pkg::QDEPTH));
   assign push      = req_channel.valid && req_channel.ready;
   assign dec_valid = (count_ff != '0);
   assign pop       = dec_valid && dec_ready;
   assign dec_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec_word;
      end
   end

endmodule

/* hw/rtl/rvx_back.sv */
// rvx_back: execute pipeline with alu, multiplier and a one-bit-per-stage divider
// depends on rvx_pkg and rvx_rsp_if
module rvx_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              dec_valid,
   input  rvx_pkg::dec_type  dec_data,
   output logic              dec_ready,
   rvx_rsp_if.source         rsp_channel
);

   typedef struct packed {
      logic        valid;
      logic [3:0]  kind;
      logic [3:0]  fn;
      logic [31:0] res;
      logic        we;
      logic        taken;
      logic [31:0] next;
      logic        dz;
      logic        neg_q;
      logic        neg_r;
      logic [31:0] opa;
      logic [31:0] rem;
      logic [31:0] quo;
      logic [31:0] dvs;
   } stage_type;

   stage_type        st_ff [rvx_pkg::DIV_STEPS+1];
   stage_type        st_in [rvx_pkg::DIV_STEPS+1];
   stage_type        st0_in;
   logic [63:0]      prod_ff, prod_in;
   logic             rsp_valid_ff;
   rvx_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             adv;

   // whole pipeline moves when the output register can take a word
   assign adv       = !rsp_valid_ff || rsp_channel.ready;
   assign dec_ready = adv;

   // first stage: alu, branch, jump, upper-immediate, multiply and divider setup
   always_comb begin
      logic [31:0]        a, b, seq, ua, ub;
      logic               cond, sgn, na, nb;
      logic signed [32:0] ma, mb;
      logic signed [65:0] pr;
      stage_type          s;
      a    = dec_data.opa;
      b    = dec_data.opb;
      seq  = dec_data.pc + rvx_pkg::INSN_BYTES;
      cond = 1'b0;
      s         = '0;
      s.valid   = dec_valid;
      s.kind    = dec_data.kind;
      s.fn      = dec_data.fn;
      s.next    = seq;
      s.opa     = a;
      case (dec_data.kind)
         rvx_pkg::K_ALU: begin
            s.we = 1'b1;
            case (dec_data.fn)
               rvx_pkg::F_ADD:  s.res = a + b;
               rvx_pkg::F_SUB:  s.res = a - b;
               rvx_pkg::F_XOR:  s.res = a ^ b;
               rvx_pkg::F_OR:   s.res = a | b;
               rvx_pkg::F_AND:  s.res = a & b;
               rvx_pkg::F_SLL:  s.res = a << b[4:0];
               rvx_pkg::F_SRL:  s.res = a >> b[4:0];
               rvx_pkg::F_SRA:  s.res = $unsigned($signed(a) >>> b[4:0]);
               rvx_pkg::F_SLT:  s.res = {31'd0, $signed(a) < $signed(b)};
               rvx_pkg::F_SLTU: s.res = {31'd0, a < b};
               default:         s.res = '0;
            endcase
         end
         rvx_pkg::K_MUL: s.we = 1'b1;
         rvx_pkg::K_DIV: s.we = 1'b1;
         rvx_pkg::K_BR: begin
            case (dec_data.fn)
               rvx_pkg::F_BEQ:  cond = (a == b);
               rvx_pkg::F_BNE:  cond = (a != b);
               rvx_pkg::F_BLT:  cond = $signed(a) < $signed(b);
               rvx_pkg::F_BGE:  cond = $signed(a) >= $signed(b);
               rvx_pkg::F_BLTU: cond = a < b;
               rvx_pkg::F_BGEU: cond = a >= b;
               default:         cond = 1'b0;
            endcase
            s.taken = cond;
            if (cond) begin
               s.next = dec_data.pc + dec_data.imm;
            end
         end
         rvx_pkg::K_JAL: begin
            s.we    = 1'b1;
            s.taken = 1'b1;
            s.res   = seq;
            s.next  = dec_data.pc + dec_data.imm;
         end
         rvx_pkg::K_JALR: begin
            s.we    = 1'b1;
            s.taken = 1'b1;
            s.res   = seq;
            s.next  = (a + dec_data.imm) & ~32'd1;
         end
         rvx_pkg::K_LUI: begin
            s.we  = 1'b1;
            s.res = dec_data.imm << rvx_pkg::UPPER_SHIFT;
         end
         rvx_pkg::K_AUIPC: begin
            s.we  = 1'b1;
            s.res = dec_data.pc + (dec_data.imm << rvx_pkg::UPPER_SHIFT);
         end
         default: s.we = 1'b0;
      endcase

      // divider operands as magnitudes
      sgn     = (dec_data.fn == rvx_pkg::F_DIV) || (dec_data.fn == rvx_pkg::F_REM);
      na      = sgn && a[31];
      nb      = sgn && b[31];
      ua      = na ? 32'd0 - a : a;
      ub      = nb ? 32'd0 - b : b;
      s.dz    = (dec_data.kind == rvx_pkg::K_DIV) && (b == '0);
      s.neg_q = na ^ nb;
      s.neg_r = na;
      s.rem   = '0;
      s.quo   = ua;
      s.dvs   = ub;
      st0_in  = s;

      // 33x33 signed product covers all four multiply forms
      ma = $signed({(dec_data.fn == rvx_pkg::F_MULH || dec_data.fn == rvx_pkg::F_MULHSU)
                    && a[31], a});
      mb = $signed({(dec_data.fn == rvx_pkg::F_MULH) && b[31], b});
      pr = ma * mb;
      prod_in = pr[63:0];
   end

   // divider steps, one quotient bit per stage
   always_comb begin
      logic [32:0] t;
      stage_type   s;
      st_in[0] = st0_in;
      for (int k = 1; k <= rvx_pkg::DIV_STEPS; k++) begin
         s = st_ff[k-1];
         // product word picked right after the multiplier register
         if (k == 1 && s.kind == rvx_pkg::K_MUL) begin
            s.res = (s.fn == rvx_pkg::F_MUL) ? prod_ff[31:0] : prod_ff[63:32];
         end
         t = {s.rem, s.quo[31]} - {1'b0, s.dvs};
         if (!t[32]) begin
            s.rem = t[31:0];
            s.quo = {s.quo[30:0], 1'b1};
         end else begin
            s.rem = {s.rem[30:0], s.quo[31]};
            s.quo = {s.quo[30:0], 1'b0};
         end
         st_in[k] = s;
      end
   end

   // sign fix and zero-divisor values
   always_comb begin
      stage_type s;
      logic      is_rem;
      s = st_ff[rvx_pkg::DIV_STEPS];
      is_rem = (s.fn == rvx_pkg::F_REM) || (s.fn == rvx_pkg::F_REMU);
      rsp_data_in.result_value   = s.res;
      rsp_data_in.write_enable   = s.we;
      rsp_data_in.branch_taken   = s.taken;
      rsp_data_in.next_address   = s.next;
      rsp_data_in.divide_by_zero = s.dz;
      if (s.kind == rvx_pkg::K_DIV) begin
         if (s.dz) begin
            rsp_data_in.result_value = is_rem ? s.opa : '1;
         end else if (is_rem) begin
            rsp_data_in.result_value = s.neg_r ? 32'd0 - s.rem : s.rem;
         end else begin
            rsp_data_in.result_value = s.neg_q ? 32'd0 - s.quo : s.quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= rvx_pkg::DIV_STEPS; k++) begin
            st_ff[k].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k <= rvx_pkg::DIV_STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
         rsp_valid_ff <= st_ff[rvx_pkg::DIV_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff     <= prod_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_data_ff;

endmodule

/* hw/rtl/rv32im_execute_unit_core.sv */
// rv32im_execute_unit_core: top level of the rv32im execute unit
// depends on rvx_pkg, rvx_if, rvx_front and rvx_back
//
// Executes one RV32IM arithmetic, multiply/divide, branch, jump or upper-immediate
// word per cycle. A word enters a four-deep queue after decode; the execute side
// is a fixed 34-stage pipeline (one setup stage with the multiplier, 32 divider
// stages that each resolve one quotient bit, and the output register), so every
// word, whatever its kind, passes through all of these stages, and words leave in
// order. Throughput is one word per cycle while the result side takes words; a
// stall on the result side freezes the pipeline and the queue absorbs up to four
// more requests. Division by zero returns all ones (or the dividend for a
// remainder) and sets divide_by_zero. No clearing pass or setup after reset.
module rv32im_execute_unit_core (
   input  logic      clock,
   input  logic      reset,
   rvx_req_if.sink   req_channel,
   rvx_rsp_if.source rsp_channel
);

   logic             dec_valid;
   logic             dec_ready;
   rvx_pkg::dec_type dec_data;

   // decode and queue
   rvx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .dec_valid   (dec_valid),
      .dec_data    (dec_data),
      .dec_ready   (dec_ready)
   );

   // execute pipeline
   rvx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .dec_valid   (dec_valid),
      .dec_data    (dec_data),
      .dec_ready   (dec_ready),
      .rsp_channel (rsp_channel)
   );

endmodule

/* tb/rv32im_execute_unit_core_checker.sv */
// rv32im_execute_unit_core_checker: predicts each execute result and compares it
// depends on rvx_pkg for op codes and payload types, and on rvx_if for the channels
module rv32im_execute_unit_core_checker (
   input  logic      clock,
   input  logic      reset,
   rvx_req_if.sink   req_mon,
   rvx_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending_count,
   output logic      rsp_seen
);

   rvx_pkg::rsp_type expected_q[$];

   // signed compare of two words
   function automatic logic lt_signed(logic [31:0] x, logic [31:0] y);
      return $signed(x) < $signed(y);
   endfunction

   // arithmetic shift right by the low 5 bits
   function automatic logic [31:0] shift_arith(logic [31:0] v, logic [31:0] amt);
      return $signed(v) >>> amt[4:0];
   endfunction

   // signed divide or remainder with magnitude arithmetic
   function automatic logic [31:0] signed_divide(logic [31:0] x, logic [31:0] y,
                                                 logic want_rem);
      logic [31:0] ux, uy, q, r;
      ux = x[31] ? -x : x;
      uy = y[31] ? -y : y;
      q = ux / uy;
      r = ux % uy;
      if (want_rem) return x[31] ? -r : r;
      return (x[31] != y[31]) ? -q : q;
   endfunction

   // execute-stage result for one instruction word
   function automatic rvx_pkg::rsp_type execute_result(rvx_pkg::req_type w);
      rvx_pkg::rsp_type o;
      logic [31:0] a, b, imm, pc, seq, res, nxt;
      logic [63:0] prod;
      logic we, tk, dz, cond;
      a = w.source_a; b = w.source_b; imm = w.immediate; pc = w.program_counter;
      seq = pc + rvx_pkg::INSN_BYTES;
      res = '0; nxt = seq; we = 1'b0; tk = 1'b0; dz = 1'b0; cond = 1'b0;
      if (w.operation <= rvx_pkg::OP_REMU) begin
         we = 1'b1;
         case (w.operation)
            rvx_pkg::OP_ADD:    res = a + b;
            rvx_pkg::OP_SUB:    res = a - b;
            rvx_pkg::OP_XOR:    res = a ^ b;
            rvx_pkg::OP_OR:     res = a | b;
            rvx_pkg::OP_AND:    res = a & b;
            rvx_pkg::OP_SLL:    res = a << b[4:0];
            rvx_pkg::OP_SRL:    res = a >> b[4:0];
            rvx_pkg::OP_SRA:    res = shift_arith(a, b);
            rvx_pkg::OP_SLT:    res = {31'd0, lt_signed(a, b)};
            rvx_pkg::OP_SLTU:   res = {31'd0, a < b};
            rvx_pkg::OP_ADDI:   res = a + imm;
            rvx_pkg::OP_XORI:   res = a ^ imm;
            rvx_pkg::OP_ORI:    res = a | imm;
            rvx_pkg::OP_ANDI:   res = a & imm;
            rvx_pkg::OP_SLLI:   res = a << imm[4:0];
            rvx_pkg::OP_SRLI:   res = a >> imm[4:0];
            rvx_pkg::OP_SRAI:   res = shift_arith(a, imm);
            rvx_pkg::OP_SLTI:   res = {31'd0, lt_signed(a, imm)};
            rvx_pkg::OP_SLTIU:  res = {31'd0, a < imm};
            rvx_pkg::OP_MUL:    res = a * b;
            rvx_pkg::OP_MULH: begin
               prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
               res = prod[63:32];
            end
            rvx_pkg::OP_MULHSU: begin
               prod = {{32{a[31]}}, a} * {32'd0, b};
               res = prod[63:32];
            end
            rvx_pkg::OP_MULHU: begin
               prod = {32'd0, a} * {32'd0, b};
               res = prod[63:32];
            end
            default: begin
               if (b == '0) begin
                  dz = 1'b1;
                  res = (w.operation == rvx_pkg::OP_DIV || w.operation == rvx_pkg::OP_DIVU)
                        ? '1 : a;
               end else if (w.operation == rvx_pkg::OP_DIV) res = signed_divide(a, b, 1'b0);
               else if (w.operation == rvx_pkg::OP_DIVU) res = a / b;
               else if (w.operation == rvx_pkg::OP_REM) res = signed_divide(a, b, 1'b1);
               else res = a % b;
            end
         endcase
      end else if (w.operation <= rvx_pkg::OP_BGEU) begin
         case (w.operation)
            rvx_pkg::OP_BEQ:  cond = a == b;
            rvx_pkg::OP_BNE:  cond = a != b;
            rvx_pkg::OP_BLT:  cond = lt_signed(a, b);
            rvx_pkg::OP_BGE:  cond = !lt_signed(a, b);
            rvx_pkg::OP_BLTU: cond = a < b;
            default:          cond = a >= b;
         endcase
         if (cond) begin
            tk = 1'b1;
            nxt = pc + imm;
         end
      end else if (w.operation == rvx_pkg::OP_JAL) begin
         we = 1'b1; tk = 1'b1; res = seq; nxt = pc + imm;
      end else if (w.operation == rvx_pkg::OP_JALR) begin
         we = 1'b1; tk = 1'b1; res = seq; nxt = (a + imm) & ~32'd1;
      end else if (w.operation == rvx_pkg::OP_LUI) begin
         we = 1'b1; res = imm << rvx_pkg::UPPER_SHIFT;
      end else if (w.operation == rvx_pkg::OP_AUIPC) begin
         we = 1'b1; res = pc + (imm << rvx_pkg::UPPER_SHIFT);
      end
      o.result_value = res;
      o.write_enable = we;
      o.branch_taken = tk;
      o.next_address = nxt;
      o.divide_by_zero = dz;
      return o;
   endfunction

   assign pending_count = expected_q.size();

   // watch both channels, compare in order, then predict on accept
   always @(posedge clock) begin
      rvx_pkg::rsp_type exp_w, act_w;
      if (reset) begin
         fail_count <= 0;
         rsp_seen <= 1'b0;
      end else begin
         rsp_seen <= rsp_mon.valid && rsp_mon.ready;
         if (rsp_mon.valid && rsp_mon.ready) begin
            act_w = rsp_mon.payload;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual %h", $time, act_w);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = expected_q.pop_front();
               if (act_w !== exp_w) begin
                  $display("%0t: mismatch: expected val=%h we=%b tk=%b next=%h dz=%b",
                           $time, exp_w.result_value, exp_w.write_enable,
                           exp_w.branch_taken, exp_w.next_address, exp_w.divide_by_zero);
                  $display("%0t:           actual val=%h we=%b tk=%b next=%h dz=%b",
                           $time, act_w.result_value, act_w.write_enable,
                           act_w.branch_taken, act_w.next_address, act_w.divide_by_zero);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_q.insert(expected_q.size(), execute_result(req_mon.payload));
      end
   end
endmodule

/* tb/rv32im_execute_unit_core_tb.sv */
// rv32im_execute_unit_core_tb: drives instruction words and stalls the result side
// depends on rvx_pkg, rvx_if, the checker module and rv32im_execute_unit_core
module rv32im_execute_unit_core_tb;

   localparam int RANDOM_WORDS = 1800;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_START   = 800;
   localparam int HOLD_CYCLES  = 200;

   logic clock;
   logic reset;
   int   fail_count, pending_count;
   logic rsp_seen;
   int   idle_cycles;

   rvx_req_if req_channel();
   rvx_rsp_if rsp_channel();

   rv32im_execute_unit_core dut (
      .clock(clock), .reset(reset),
      .req_channel(req_channel.sink), .rsp_channel(rsp_channel.source)
   );

   rv32im_execute_unit_core_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_mon(req_channel.sink), .rsp_mon(rsp_channel.sink),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_seen(rsp_seen)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // interesting operand values
   function automatic logic [31:0] edge_value();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'h1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // random word, mostly defined operations
   function automatic rvx_pkg::req_type random_word();
      rvx_pkg::req_type w;
      w.operation = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(37, 63))
                                                 : 6'($urandom_range(0, 36));
      w.source_a = edge_value();
      w.source_b = ($urandom_range(0, 7) == 0) ? 32'h0 : edge_value();
      if ($urandom_range(0, 3) == 0) w.source_b = w.source_a;
      w.immediate = edge_value();
      w.program_counter = $urandom;
      return w;
   endfunction

   // offer one word and wait for it to be taken
   task automatic send_word(rvx_pkg::req_type w);
      req_channel.valid <= 1;
      req_channel.payload <= w;
      @(posedge clock);
      while (!req_channel.ready) @(posedge clock);
   endtask

   // drop valid for a random gap
   task automatic idle_gap(int n);
      if (n > 0) begin
         req_channel.valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // receiver stall pattern plus one long hold-off counted in cycles
   initial begin
      int phase;
      rsp_channel.ready = 0;
      phase = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         phase++;
         if (phase >= HOLD_START && phase < HOLD_START + HOLD_CYCLES) rsp_channel.ready <= 0;
         else if ((phase / 50) % 3 == 0) rsp_channel.ready <= 1;
         else rsp_channel.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_channel.valid && req_channel.ready) || rsp_seen) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      rvx_pkg::req_type w;
      int burst, cnt;
      reset = 1;
      req_channel.valid = 0;
      req_channel.payload = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every defined code with edge operands, including
      // divide by zero and signed overflow of divide
      for (int op = 0; op <= 36; op++) begin
         w.operation = 6'(op);
         w.source_a = 32'h8000_0000;
         w.source_b = (op == rvx_pkg::OP_REM || op == rvx_pkg::OP_DIV) ? 32'hFFFF_FFFF
                                                                       : 32'hFFFF_FFF3;
         w.immediate = 32'hFFFF_F803;
         w.program_counter = 32'hFFFF_FFFC;
         send_word(w);
      end
      w = '0; w.operation = rvx_pkg::OP_DIVU; w.source_a = 32'h1234_5678; send_word(w);
      w.operation = rvx_pkg::OP_REMU; send_word(w);
      w.operation = rvx_pkg::OP_DIV; send_word(w);
      w.operation = rvx_pkg::OP_REM; send_word(w);
      w.operation = 6'h3F; w.source_a = '1; w.source_b = '1; w.immediate = '1;
      w.program_counter = '1; send_word(w);
      w.operation = rvx_pkg::OP_JALR; w.source_a = 32'h0000_1001; w.immediate = 32'h0;
      send_word(w);

      // random bursts with random gaps
      cnt = 0;
      while (cnt < RANDOM_WORDS) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && cnt < RANDOM_WORDS; k++) begin
            send_word(random_word());
            cnt++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
      end
      req_channel.valid <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
